/* design/assert_macros.svh */
// Assertion helpers used by the SVA checker in design/owbm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

/* design/owbm_pkg.sv */
`timescale 1ns / 1ps

package owbm_pkg;

   // Bus timing and byte framing
   localparam int BITS_PER_BYTE = 8;
   localparam int BITS_LEFT_W   = $clog2(BITS_PER_BYTE + 1);
   localparam int TICK_W        = 10;
   localparam int NUM_REGS      = 8;
   localparam int REG_IDX_W     = $clog2(NUM_REGS);
   localparam int ADDR_W        = REG_IDX_W + 2;
   localparam int DATA_W        = 32;

   // Command codes
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_RESET = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_RESET_WAIT   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ZERO_LOW     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ZERO_RECOVER = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SHORT_LOW    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ONE_RELEASE  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE  = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_READ_RECOVER = 3'd7;

   typedef logic [NUM_REGS-1:0][TICK_W-1:0] csr_bank_type;

   // Reset values, index 0 in the low slice
   localparam csr_bank_type REG_DEFAULTS = {
      10'd45, 10'd10, 10'd85, 10'd5, 10'd5, 10'd60, 10'd480, 10'd480
   };

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] write_byte;
      logic       line_level;
   } req_item_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       rejected;
      logic [7:0] read_byte;
      logic       presence_seen;
   } rsp_item_type;

   // A zero-length phase lasts one tick
   function automatic logic [TICK_W-1:0] dur(input logic [TICK_W-1:0] v);
      return (v == '0) ? TICK_W'(1) : v;
   endfunction

endpackage

/* design/owbm_csr.sv */
`timescale 1ns / 1ps

module owbm_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [owbm_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [owbm_pkg::DATA_W-1:0] csr_pwdata,
   output logic [owbm_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready,
   output owbm_pkg::csr_bank_type      bank
);

   owbm_pkg::csr_bank_type                bank_ff;
   owbm_pkg::csr_bank_type                bank_in;
   logic [owbm_pkg::REG_IDX_W-1:0]        idx;

   assign idx        = csr_paddr[owbm_pkg::ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign csr_prdata = owbm_pkg::DATA_W'(bank_ff[idx]);
   assign bank       = bank_ff;

   // Write on the access phase
   always_comb begin
      bank_in = bank_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         bank_in[idx] = csr_pwdata[owbm_pkg::TICK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= owbm_pkg::REG_DEFAULTS;
      end else begin
         bank_ff <= bank_in;
      end
   end

endmodule

/* design/owbm_core.sv */
`timescale 1ns / 1ps

module owbm_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  owbm_pkg::req_item_type item,
   input  owbm_pkg::csr_bank_type bank,
   output owbm_pkg::rsp_item_type rsp_data
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RST_LOW,
      PH_RST_WAIT,
      PH_BIT_LOW,
      PH_BIT_REL,
      PH_RD_LOW,
      PH_RD_WAIT,
      PH_RD_REC
   } phase_type;

   phase_type                           phase_ff,   phase_in;
   logic [owbm_pkg::TICK_W-1:0]         tick_ff,    tick_in;
   logic [owbm_pkg::BITS_LEFT_W-1:0]    bits_ff,    bits_in;
   logic [7:0]                          shift_ff,   shift_in;
   logic                                bit_ff,     bit_in;
   logic                                pres_ff,    pres_in;
   logic [7:0]                          last_ff,    last_in;
   owbm_pkg::rsp_item_type              rsp_ff,     rsp_in;

   logic [owbm_pkg::TICK_W-1:0]         len;
   logic                                end_tick;
   logic                                drive;
   logic                                done;
   logic                                rej;

   // One tick of the bus sequencer
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bits_in  = bits_ff;
      shift_in = shift_ff;
      bit_in   = bit_ff;
      pres_in  = pres_ff;
      last_in  = last_ff;
      drive    = 1'b0;
      done     = 1'b0;
      rej      = 1'b0;
      len      = owbm_pkg::TICK_W'(1);
      end_tick = 1'b0;

      // start command, or reject when busy
      if (phase_ff != PH_IDLE) begin
         rej = (item.func != owbm_pkg::FUNC_TICK);
      end else if (item.func != owbm_pkg::FUNC_TICK) begin
         tick_in = '0;
         case (item.func)
            owbm_pkg::FUNC_RESET: begin
               phase_in = PH_RST_LOW;
            end
            owbm_pkg::FUNC_WRITE: begin
               shift_in = item.write_byte;
               bits_in  = owbm_pkg::BITS_LEFT_W'(owbm_pkg::BITS_PER_BYTE);
               bit_in   = item.write_byte[0];
               phase_in = PH_BIT_LOW;
            end
            default: begin
               shift_in = '0;
               bits_in  = owbm_pkg::BITS_LEFT_W'(owbm_pkg::BITS_PER_BYTE);
               phase_in = PH_RD_LOW;
            end
         endcase
      end

      // line drive, phase length and samples
      case (phase_in)
         PH_RST_LOW: begin
            drive = 1'b1;
            len   = owbm_pkg::dur(bank[owbm_pkg::REG_RESET_LOW]);
         end
         PH_RST_WAIT: begin
            len = owbm_pkg::dur(bank[owbm_pkg::REG_RESET_WAIT]);
            if (tick_in == '0) begin
               pres_in = ~item.line_level;
            end
         end
         PH_BIT_LOW: begin
            drive = 1'b1;
            len   = bit_in ? owbm_pkg::dur(bank[owbm_pkg::REG_SHORT_LOW])
                           : owbm_pkg::dur(bank[owbm_pkg::REG_ZERO_LOW]);
         end
         PH_BIT_REL: begin
            len = bit_in ? owbm_pkg::dur(bank[owbm_pkg::REG_ONE_RELEASE])
                         : owbm_pkg::dur(bank[owbm_pkg::REG_ZERO_RECOVER]);
         end
         PH_RD_LOW: begin
            drive = 1'b1;
            len   = owbm_pkg::dur(bank[owbm_pkg::REG_SHORT_LOW]);
         end
         PH_RD_WAIT: begin
            len = owbm_pkg::dur(bank[owbm_pkg::REG_READ_SAMPLE]);
         end
         PH_RD_REC: begin
            len = owbm_pkg::dur(bank[owbm_pkg::REG_READ_RECOVER]);
            if (tick_in == '0) begin
               shift_in = {item.line_level, shift_in[7:1]};
            end
         end
         default: begin
            len = owbm_pkg::TICK_W'(1);
         end
      endcase

      // tick count and phase advance
      if (phase_in != PH_IDLE) begin
         end_tick = ({1'b0, tick_in} + 1'b1) >= {1'b0, len};
         tick_in  = tick_in + 1'b1;
         if (end_tick) begin
            tick_in = '0;
            case (phase_in)
               PH_RST_LOW: begin
                  phase_in = PH_RST_WAIT;
               end
               PH_RST_WAIT: begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end
               PH_BIT_LOW: begin
                  phase_in = PH_BIT_REL;
               end
               PH_BIT_REL: begin
                  shift_in = {1'b0, shift_in[7:1]};
                  if (bits_in != '0) begin
                     bits_in = bits_in - 1'b1;
                  end
                  if (bits_in == '0) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     bit_in   = shift_in[0];
                     phase_in = PH_BIT_LOW;
                  end
               end
               PH_RD_LOW: begin
                  phase_in = PH_RD_WAIT;
               end
               PH_RD_WAIT: begin
                  phase_in = PH_RD_REC;
               end
               PH_RD_REC: begin
                  if (bits_in != '0) begin
                     bits_in = bits_in - 1'b1;
                  end
                  if (bits_in == '0) begin
                     last_in  = shift_in;
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     phase_in = PH_RD_LOW;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end

      rsp_in.drive_low     = drive;
      rsp_in.busy_res      = (phase_in != PH_IDLE);
      rsp_in.done_res      = done;
      rsp_in.rejected      = rej;
      rsp_in.read_byte     = last_in;
      rsp_in.presence_seen = pres_in;
   end

   // State and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bits_ff  <= '0;
         shift_ff <= '0;
         bit_ff   <= 1'b0;
         pres_ff  <= 1'b0;
         last_ff  <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
         bit_ff   <= bit_in;
         pres_ff  <= pres_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* design/one_wire_bus_master.sv */
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle unless results stall; each is one bus tick, in one pass.
// The result register frees up in the same cycle it is taken, so no bubbles under load.
// Reset (synchronous, active high) clears the sequencer, flags and read byte, empties
// both registers and loads the timing registers with their default tick counts.
`timescale 1ns / 1ps

module one_wire_bus_master (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  owbm_pkg::req_item_type      req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output owbm_pkg::rsp_item_type      rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [owbm_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [owbm_pkg::DATA_W-1:0] csr_pwdata,
   output logic [owbm_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);

   logic                   s1_valid_ff, s1_valid_in;
   owbm_pkg::req_item_type s1_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   advance;
   owbm_pkg::csr_bank_type bank;

   // Item moves into the result register when that register is free or being taken
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
   end

   owbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .bank        (bank)
   );

   owbm_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .item     (s1_data_ff),
      .bank     (bank),
      .rsp_data (rsp_data)
   );

endmodule

/* design/owbm_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module owbm_sva (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input owbm_pkg::rsp_item_type rsp_data
);

   // A stalled result item stays put
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // An operation that finishes is no longer busy
   `ASSERT_IMPLIES(a_done_idle, clock, reset, rsp_valid && rsp_data.done_res, !rsp_data.busy_res)

   // The line is only pulled low inside an operation that continues
   `ASSERT_IMPLIES(a_drive_busy, clock, reset, rsp_valid && rsp_data.drive_low, rsp_data.busy_res && !rsp_data.done_res)

   // Nothing is offered right after reset
   `ASSERT_IMPLIES(a_reset_empty, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

bind one_wire_bus_master owbm_sva u_owbm_sva (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* verif/owbm_checker.sv */
`timescale 1ns / 1ps

module owbm_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  owbm_pkg::req_item_type      req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  owbm_pkg::rsp_item_type      rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [owbm_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [owbm_pkg::DATA_W-1:0] csr_pwdata,
   input  logic [owbm_pkg::DATA_W-1:0] csr_prdata,
   input  logic                        csr_pready,
   output int                          mismatches,
   output int                          pending,
   output int                          checked
);
   import owbm_pkg::*;

   // Bus sequencer phases of the predictor
   typedef enum logic [3:0] {
      BUS_IDLE,
      RST_LOW,
      RST_WAIT,
      BIT_LOW,
      BIT_REL,
      SLOT_LOW,
      SLOT_WAIT,
      SLOT_SAMPLE
   } bus_phase_e;

   // Predictor copy of the timing registers and the sequencer state
   logic [TICK_W-1:0]      tick_cfg [NUM_REGS];
   bus_phase_e             phase;
   logic [TICK_W-1:0]      tick_cnt;
   logic [BITS_LEFT_W-1:0] bits_left;
   logic [7:0]             shifter;
   logic [7:0]             last_read;
   logic                   cur_bit;
   logic                   presence;

   // Expected results, one per accepted bus tick, oldest first
   rsp_item_type tick_results_q [$];
   int           fail_cnt   = 0;
   int           result_cnt = 0;

   // A zero tick count still lasts one tick
   function automatic logic [TICK_W:0] span_of(input logic [TICK_W-1:0] v);
      return (v == '0) ? (TICK_W + 1)'(1) : {1'b0, v};
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      fail_cnt++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   task automatic load_defaults;
      tick_cfg[REG_RESET_LOW]    = 10'd480;
      tick_cfg[REG_RESET_WAIT]   = 10'd480;
      tick_cfg[REG_ZERO_LOW]     = 10'd60;
      tick_cfg[REG_ZERO_RECOVER] = 10'd5;
      tick_cfg[REG_SHORT_LOW]    = 10'd5;
      tick_cfg[REG_ONE_RELEASE]  = 10'd85;
      tick_cfg[REG_READ_SAMPLE]  = 10'd10;
      tick_cfg[REG_READ_RECOVER] = 10'd45;
   endtask

   // One bus tick: start handling, phase action, then the phase-end step
   task automatic advance_bus_tick(input req_item_type it, output rsp_item_type res);
      logic            drive;
      logic            done;
      logic            rej;
      logic            fin;
      logic [TICK_W:0] len;
      drive = 1'b0;
      done  = 1'b0;
      rej   = 1'b0;
      len   = (TICK_W + 1)'(1);

      if (phase != BUS_IDLE) begin
         if (it.func != FUNC_TICK)
            rej = 1'b1;
      end else if (it.func != FUNC_TICK) begin
         tick_cnt = '0;
         case (it.func)
            FUNC_RESET: begin
               phase = RST_LOW;
            end
            FUNC_WRITE: begin
               shifter   = it.write_byte;
               bits_left = BITS_LEFT_W'(BITS_PER_BYTE);
               cur_bit   = it.write_byte[0];
               phase     = BIT_LOW;
            end
            default: begin
               shifter   = '0;
               bits_left = BITS_LEFT_W'(BITS_PER_BYTE);
               phase     = SLOT_LOW;
            end
         endcase
      end

      case (phase)
         RST_LOW: begin
            drive = 1'b1;
            len   = span_of(tick_cfg[REG_RESET_LOW]);
         end
         RST_WAIT: begin
            len = span_of(tick_cfg[REG_RESET_WAIT]);
            // presence: a device holds the line low on the first released tick
            if (tick_cnt == '0)
               presence = ~it.line_level;
         end
         BIT_LOW: begin
            drive = 1'b1;
            len   = cur_bit ? span_of(tick_cfg[REG_SHORT_LOW]) : span_of(tick_cfg[REG_ZERO_LOW]);
         end
         BIT_REL: begin
            len = cur_bit ? span_of(tick_cfg[REG_ONE_RELEASE])
                          : span_of(tick_cfg[REG_ZERO_RECOVER]);
         end
         SLOT_LOW: begin
            drive = 1'b1;
            len   = span_of(tick_cfg[REG_SHORT_LOW]);
         end
         SLOT_WAIT: begin
            len = span_of(tick_cfg[REG_READ_SAMPLE]);
         end
         SLOT_SAMPLE: begin
            len = span_of(tick_cfg[REG_READ_RECOVER]);
            // bits arrive LSB first, so each sample enters at the top
            if (tick_cnt == '0)
               shifter = {it.line_level, shifter[7:1]};
         end
         default: ;
      endcase

      if (phase != BUS_IDLE) begin
         fin      = ({1'b0, tick_cnt} + (TICK_W + 1)'(1)) >= len;
         tick_cnt = tick_cnt + 1'b1;
         if (fin) begin
            tick_cnt = '0;
            case (phase)
               RST_LOW: begin
                  phase = RST_WAIT;
               end
               RST_WAIT: begin
                  phase = BUS_IDLE;
                  done  = 1'b1;
               end
               BIT_LOW: begin
                  phase = BIT_REL;
               end
               BIT_REL: begin
                  shifter = shifter >> 1;
                  if (bits_left != '0)
                     bits_left = bits_left - 1'b1;
                  if (bits_left == '0) begin
                     phase = BUS_IDLE;
                     done  = 1'b1;
                  end else begin
                     cur_bit = shifter[0];
                     phase   = BIT_LOW;
                  end
               end
               SLOT_LOW: begin
                  phase = SLOT_WAIT;
               end
               SLOT_WAIT: begin
                  phase = SLOT_SAMPLE;
               end
               SLOT_SAMPLE: begin
                  if (bits_left != '0)
                     bits_left = bits_left - 1'b1;
                  if (bits_left == '0) begin
                     last_read = shifter;
                     phase     = BUS_IDLE;
                     done      = 1'b1;
                  end else begin
                     phase = SLOT_LOW;
                  end
               end
               default: begin
                  phase = BUS_IDLE;
               end
            endcase
         end
      end

      res.drive_low     = drive;
      res.busy_res      = (phase != BUS_IDLE);
      res.done_res      = done;
      res.rejected      = rej;
      res.read_byte     = last_read;
      res.presence_seen = presence;
   endtask

   // Watch all three ports on the rising edge
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         load_defaults();
         phase     = BUS_IDLE;
         tick_cnt  = '0;
         bits_left = '0;
         shifter   = '0;
         last_read = '0;
         cur_bit   = 1'b0;
         presence  = 1'b0;
         tick_results_q.delete();
      end else begin
         // register writes and read-back
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite)
               tick_cfg[csr_paddr[ADDR_W-1:2]] = csr_pwdata[TICK_W-1:0];
            else
               check_field("register read", csr_prdata,
                           DATA_W'(tick_cfg[csr_paddr[ADDR_W-1:2]]));
         end

         if (req_valid && req_ready) begin
            advance_bus_tick(req_data, want);
            tick_results_q.push_back(want);
         end

         if (rsp_valid && rsp_ready) begin
            if (tick_results_q.size() == 0) begin
               report_mismatch("result with none expected", 32'(rsp_data), '0);
            end else begin
               want = tick_results_q.pop_front();
               check_field("drive_low", 32'(rsp_data.drive_low), 32'(want.drive_low));
               check_field("busy_res", 32'(rsp_data.busy_res), 32'(want.busy_res));
               check_field("done_res", 32'(rsp_data.done_res), 32'(want.done_res));
               check_field("rejected", 32'(rsp_data.rejected), 32'(want.rejected));
               check_field("read_byte", 32'(rsp_data.read_byte), 32'(want.read_byte));
               check_field("presence_seen", 32'(rsp_data.presence_seen),
                           32'(want.presence_seen));
               result_cnt++;
            end
         end
      end
      mismatches <= fail_cnt;
      pending    <= tick_results_q.size();
      checked    <= result_cnt;
   end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import owbm_pkg::*;

   localparam int RANDOM_TICKS = 250;
   localparam int CYCLE_LIMIT  = 2_000_000;

   // line level choices while an operation runs
   localparam int LINE_LOW    = 0;
   localparam int LINE_HIGH   = 1;
   localparam int LINE_RANDOM = 2;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   req_item_type        req_data    = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   rsp_item_type        rsp_data;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr   = '0;
   logic [DATA_W-1:0]   csr_pwdata  = '0;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   int   mismatches;
   int   pending;
   int   checked;
   int   done_count  = 0;
   logic bus_busy    = 1'b0;
   bit   quiet       = 1'b0;
   int   rsp_wait    = 0;
   int   cycles      = 0;
   int   ticks_sent  = 0;
   int   starts_sent = 0;
   int   setups      = 0;

   one_wire_bus_master dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   owbm_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .mismatches (mismatches),
      .pending    (pending),
      .checked    (checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result side: after each accepted item, stall at random unless quiet is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_wait = 0;
      end else if (rsp_ready) begin
         if (rsp_valid) begin
            rsp_wait = quiet ? 0 : $urandom_range(0, 7);
            if (rsp_wait != 0)
               rsp_ready <= 1'b0;
         end
      end else if (rsp_wait > 1) begin
         rsp_wait--;
      end else begin
         rsp_wait = 0;
         rsp_ready <= 1'b1;
      end
   end

   // Track bus progress for the sequencing below; watchdog
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_valid && rsp_ready) begin
         bus_busy <= rsp_data.busy_res;
         if (rsp_data.done_res)
            done_count <= done_count + 1;
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("[one_wire_bus_master] ERROR");
         $finish;
      end
   end

   function automatic req_item_type make_item(input logic [1:0] f, input logic [7:0] b,
                                              input logic lvl);
      req_item_type it;
      it.func       = f;
      it.write_byte = b;
      it.line_level = lvl;
      return it;
   endfunction

   function automatic logic line_bit(input int mode);
      if (mode == LINE_RANDOM)
         return 1'($urandom_range(0, 1));
      return (mode == LINE_HIGH);
   endfunction

   function automatic csr_bank_type flat_bank(input logic [TICK_W-1:0] v);
      csr_bank_type bank;
      for (int i = 0; i < NUM_REGS; i++)
         bank[i] = v;
      return bank;
   endfunction

   // One bus tick item; valid stays up across back-to-back items
   task automatic push_tick(input req_item_type it);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
      if (it.func != FUNC_TICK)
         starts_sent++;
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // Start one operation and feed ticks until its done flag comes back;
   // noise_pct of the ticks carry a stray start that should be rejected
   task automatic run_op(input logic [1:0] f, input logic [7:0] b, input int noise_pct,
                         input int mode);
      int d0;
      d0 = done_count;
      push_tick(make_item(f, b, line_bit(mode)));
      while (done_count == d0) begin
         if ($urandom_range(0, 99) < noise_pct)
            push_tick(make_item(2'($urandom_range(FUNC_RESET, FUNC_READ)),
                                8'($urandom_range(0, 255)), line_bit(mode)));
         else
            push_tick(make_item(FUNC_TICK, 8'($urandom_range(0, 255)), line_bit(mode)));
      end
   endtask

   // Drain the channels and run plain ticks until no operation is left open
   task automatic finish_bus;
      int d0;
      drain_results();
      while (bus_busy) begin
         d0 = done_count;
         while (done_count == d0)
            push_tick(make_item(FUNC_TICK, 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1))));
         drain_results();
      end
   endtask

   // APB transfer; psel/penable are left up so transfers can run back to back
   task automatic csr_access(input logic wr, input int idx, input logic [TICK_W-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= ADDR_W'(idx << 2);
      csr_pwdata  <= DATA_W'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic check_timing;
      for (int i = 0; i < NUM_REGS; i++)
         csr_access(1'b0, i, '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_timing(input csr_bank_type bank);
      for (int i = 0; i < NUM_REGS; i++)
         csr_access(1'b1, i, bank[i]);
      check_timing();
      setups++;
   endtask

   initial begin
      csr_bank_type bank;
      int           random_end;
      int           phase_end;
      int unsigned  cap;
      int           d0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Power-on timing: read back, then start a bus reset with its default low length
      check_timing();
      push_tick(make_item(FUNC_RESET, 8'h00, 1'b1));
      repeat (12)
         push_tick(make_item(FUNC_TICK, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1))));
      drain_results();
      // cut the reset short; a device answers with the line low
      write_timing(flat_bank(10'd2));
      d0 = done_count;
      while (done_count == d0)
         push_tick(make_item(FUNC_TICK, 8'h00, 1'b0));
      finish_bus();

      // Shortest timing; two registers at zero, which must act as one tick
      bank = flat_bank(10'd1);
      bank[REG_ZERO_LOW]    = '0;
      bank[REG_READ_SAMPLE] = '0;
      write_timing(bank);
      run_op(FUNC_RESET, 8'h00, 0, LINE_HIGH);
      // reset lasts two ticks: a start on its done tick is refused, the next is taken
      push_tick(make_item(FUNC_RESET, 8'h00, 1'b0));
      push_tick(make_item(FUNC_WRITE, 8'h3C, 1'b1));
      push_tick(make_item(FUNC_WRITE, 8'h3C, 1'b1));
      finish_bus();
      run_op(FUNC_WRITE, 8'hFF, 0, LINE_RANDOM);
      run_op(FUNC_WRITE, 8'h00, 0, LINE_RANDOM);
      run_op(FUNC_READ, 8'hFF, 0, LINE_HIGH);
      run_op(FUNC_READ, 8'h00, 0, LINE_LOW);
      push_tick(make_item(FUNC_TICK, 8'hFF, 1'b1));
      push_tick(make_item(FUNC_TICK, 8'h00, 1'b0));
      // every start code while a read is running
      push_tick(make_item(FUNC_READ, 8'h00, 1'b1));
      push_tick(make_item(FUNC_RESET, 8'h00, 1'b0));
      push_tick(make_item(FUNC_WRITE, 8'h5A, 1'b1));
      push_tick(make_item(FUNC_READ, 8'hFF, 1'b0));
      finish_bus();

      // Shorten the reset low time while the bus reset is already past it
      bank = flat_bank(10'd1);
      bank[REG_RESET_LOW] = 10'd40;
      write_timing(bank);
      push_tick(make_item(FUNC_RESET, 8'h00, 1'b1));
      repeat (5)
         push_tick(make_item(FUNC_TICK, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1))));
      drain_results();
      bank[REG_RESET_LOW] = 10'd3;
      write_timing(bank);
      finish_bus();

      // Random operations over short random timing setups
      random_end = ticks_sent + RANDOM_TICKS;
      while (ticks_sent < random_end) begin
         cap = 1 << $urandom_range(1, 3);
         for (int i = 0; i < NUM_REGS; i++)
            bank[i] = ($urandom_range(0, 15) == 0) ? '0 : TICK_W'($urandom_range(1, cap));
         write_timing(bank);
         phase_end = ticks_sent + 80;
         while (ticks_sent < phase_end) begin
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 8)
               run_op(2'($urandom_range(FUNC_RESET, FUNC_READ)), 8'($urandom_range(0, 255)),
                      5, LINE_RANDOM);
            else
               repeat ($urandom_range(1, 6))
                  push_tick(make_item(2'($urandom_range(FUNC_TICK, FUNC_READ)),
                                      8'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1))));
         end
         quiet = 1'b0;
         finish_bus();
      end

      // Longest tick counts, each cut short once the phase is well under way
      quiet = 1'b1;
      write_timing(flat_bank(10'd1023));
      push_tick(make_item(FUNC_RESET, 8'h00, 1'b1));
      repeat (20)
         push_tick(make_item(FUNC_TICK, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1))));
      drain_results();
      write_timing(flat_bank(10'd1));
      finish_bus();
      write_timing(flat_bank(10'd1023));
      push_tick(make_item(FUNC_READ, 8'h00, 1'b1));
      repeat (20)
         push_tick(make_item(FUNC_TICK, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1))));
      drain_results();
      write_timing(flat_bank(10'd1));
      quiet = 1'b0;
      finish_bus();

      repeat (8) @(posedge clock);
      $display("Run covered %0d bus ticks with %0d start commands and %0d finished operations,",
               ticks_sent, starts_sent, done_count);
      $display("over %0d timing setups; %0d results compared.", setups, checked);
      if (mismatches == 0 && pending == 0)
         $display("[one_wire_bus_master] OK");
      else
         $display("[one_wire_bus_master] ERROR");
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/owbm_pkg.sv
design/owbm_csr.sv
design/owbm_core.sv
design/one_wire_bus_master.sv
design/owbm_checker.sv
verif/owbm_checker.sv
verif/testbench.sv
